>>> design/pba_pkg.sv
// Package for the phase binned average core: sizes, state codes, shared types.
// No dependencies; used by pba_divider and phase_binned_average_core.
`default_nettype none
package pba_pkg;
	localparam int MaxVoxels = 4096;
	localparam int MaxBins = 64;
	localparam int AddrW = $clog2(MaxVoxels);
	localparam int CntW = $clog2(MaxVoxels + 1);
	localparam int BinW = $clog2(MaxBins);
	localparam int SumW = 29;
	localparam int DivW = 32;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_RD,
		ST_WAIT,
		ST_MUL,
		ST_DIVGO,
		ST_DIVWT,
		ST_ACC,
		ST_OUTRD,
		ST_OUTDIV,
		ST_OUTWT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic [DivW-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

>>> design/pba_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pba_pkg for widths and request types.
`default_nettype none
module pba_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pba_pkg::div_req_t  req,
	output pba_pkg::div_rsp_t       rsp
);
	localparam int W = pba_pkg::DivW;
	logic [W-1:0] quo_q, den_q;
	logic [W:0] rem_q;
	logic [$clog2(W+1)-1:0] cnt_q;
	logic [W:0] trial;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ($clog2(W+1))'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.quo = quo_q;
endmodule
`default_nettype wire

>>> design/phase_binned_average_core.sv
// Phase binned average core: voxels are taken one per cycle while loading into a
// 4096-entry store. A last voxel starts the pass: a clear of the 64-entry bin memory,
// then binning of each stored voxel and a mean per bin output, both on one shared serial
// divider (binning skips it for a zero phase range); the input is not ready during the pass.
// Depends on pba_pkg and pba_divider.
`default_nettype none
module phase_binned_average_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [15:0] voxel_phase,
	input  wire logic signed [15:0] voxel_value,
	input  wire logic        last_voxel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       bin_index,
	output logic signed [15:0] bin_mean,
	output logic [12:0]      bin_count,
	output logic             dropped_voxels,
	output logic             last_bin
);
	localparam int AW = pba_pkg::AddrW;
	localparam int CW = pba_pkg::CntW;
	localparam int BW = pba_pkg::BinW;
	localparam int SW = pba_pkg::SumW;
	localparam int DW = pba_pkg::DivW;

	pba_pkg::state_t state_q, state_d;
	logic [6:0] bins_q;
	logic [CW-1:0] vcnt_q;
	logic signed [15:0] pmin_q, pmax_q;
	logic ovf_q;
	logic [CW-1:0] idx_q;
	logic [BW:0] beff;
	logic signed [15:0] ph_rd_q, val_rd_q;
	logic [16:0] range_q;
	logic [DW-1:0] num_q;
	logic [BW-1:0] bin_q;
	logic signed [SW-1:0] sum_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic neg_q;

	logic [15:0] phase_mem [pba_pkg::MaxVoxels];
	logic [15:0] value_mem [pba_pkg::MaxVoxels];
	logic [SW-1:0] sum_mem [pba_pkg::MaxBins];
	logic [CW-1:0] cnt_mem [pba_pkg::MaxBins];

	pba_pkg::div_req_t dreq;
	pba_pkg::div_rsp_t drsp;
	pba_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {25'd0, bins_q} : 32'd0;

	always_comb begin
		if (bins_q == 7'd0) beff = (BW+1)'(1);
		else if (bins_q > 7'(pba_pkg::MaxBins)) beff = (BW+1)'(pba_pkg::MaxBins);
		else beff = bins_q[BW:0];
	end

	logic in_acc, out_acc, store_ok;
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign store_ok = (vcnt_q != CW'(pba_pkg::MaxVoxels));

	// Offset of the stored phase above the minimum, the clamped bin and the absolute sum.
	logic [16:0] off;
	assign off = (ph_rd_q > pmin_q) ? 17'(ph_rd_q - pmin_q) : 17'd0;
	logic [DW-1:0] bin_q_full;
	assign bin_q_full = drsp.quo;
	logic [BW-1:0] bin_sel;
	assign bin_sel = (bin_q_full > DW'(beff - 1'b1)) ? BW'(beff - 1'b1) : BW'(bin_q_full);
	logic [SW-1:0] abs_sum;
	assign abs_sum = sum_rd_q[SW-1] ? SW'(-sum_rd_q) : SW'(sum_rd_q);

	always_comb begin
		state_d = state_q;
		dreq = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			pba_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_acc && last_voxel) state_d = pba_pkg::ST_CLEAR;
			end
			pba_pkg::ST_CLEAR:
				if (idx_q == CW'(pba_pkg::MaxBins - 1))
					state_d = (vcnt_q == '0) ? pba_pkg::ST_OUTRD : pba_pkg::ST_RD;
			pba_pkg::ST_RD: state_d = pba_pkg::ST_WAIT;
			pba_pkg::ST_WAIT: state_d = pba_pkg::ST_MUL;
			pba_pkg::ST_MUL: state_d = (range_q == '0) ? pba_pkg::ST_ACC : pba_pkg::ST_DIVGO;
			pba_pkg::ST_DIVGO: begin
				dreq.start = 1'b1;
				dreq.num = num_q + DW'(range_q);
				dreq.den = DW'({range_q, 1'b0});
				state_d = pba_pkg::ST_DIVWT;
			end
			pba_pkg::ST_DIVWT: if (!drsp.busy) state_d = pba_pkg::ST_ACC;
			pba_pkg::ST_ACC:
				state_d = (idx_q + 1'b1 == vcnt_q) ? pba_pkg::ST_OUTRD : pba_pkg::ST_RD;
			pba_pkg::ST_OUTRD: state_d = pba_pkg::ST_OUTDIV;
			pba_pkg::ST_OUTDIV: begin
				dreq.start = 1'b1;
				dreq.num = DW'(abs_sum);
				dreq.den = (cnt_rd_q == '0) ? DW'(1) : DW'(cnt_rd_q);
				state_d = pba_pkg::ST_OUTWT;
			end
			pba_pkg::ST_OUTWT: if (!drsp.busy) state_d = pba_pkg::ST_OUT;
			pba_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = last_bin ? pba_pkg::ST_LOAD : pba_pkg::ST_OUTRD;
			end
			default: state_d = pba_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pba_pkg::ST_LOAD;
			bins_q <= 7'd64;
			vcnt_q <= '0;
			pmin_q <= 16'sh7fff;
			pmax_q <= 16'sh8000;
			ovf_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == 2'd0) bins_q <= pwdata[6:0];
			case (state_q)
				pba_pkg::ST_LOAD: begin
					idx_q <= '0;
					if (in_acc) begin
						if (store_ok) begin
							vcnt_q <= vcnt_q + 1'b1;
							if (voxel_phase < pmin_q) pmin_q <= voxel_phase;
							if (voxel_phase > pmax_q) pmax_q <= voxel_phase;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				pba_pkg::ST_CLEAR:
					idx_q <= (idx_q == CW'(pba_pkg::MaxBins - 1)) ? '0 : idx_q + 1'b1;
				pba_pkg::ST_ACC:
					idx_q <= (idx_q + 1'b1 == vcnt_q) ? '0 : idx_q + 1'b1;
				pba_pkg::ST_OUT:
					if (out_ready) begin
						if (last_bin) begin
							idx_q <= '0;
							vcnt_q <= '0;
							pmin_q <= 16'sh7fff;
							pmax_q <= 16'sh8000;
							ovf_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && store_ok) begin
			phase_mem[vcnt_q[AW-1:0]] <= voxel_phase;
			value_mem[vcnt_q[AW-1:0]] <= voxel_value;
		end
		if (state_q == pba_pkg::ST_RD) begin
			ph_rd_q <= phase_mem[idx_q[AW-1:0]];
			val_rd_q <= value_mem[idx_q[AW-1:0]];
		end
		if (state_q == pba_pkg::ST_CLEAR) begin
			range_q <= (pmax_q > pmin_q) ? 17'(pmax_q - pmin_q) : 17'd0;
		end
		if (state_q == pba_pkg::ST_WAIT) num_q <= DW'({off, 1'b0}) * DW'(beff - 1'b1);
		if (state_q == pba_pkg::ST_MUL) bin_q <= '0;
		if (state_q == pba_pkg::ST_DIVWT && !drsp.busy) bin_q <= bin_sel;
		// Bin memory: read in OUTRD, MUL or DIVWT, written in CLEAR or ACC.
		if (state_q == pba_pkg::ST_WAIT || state_q == pba_pkg::ST_OUTRD) begin
			sum_rd_q <= (state_q == pba_pkg::ST_OUTRD) ? sum_mem[idx_q[BW-1:0]] : sum_rd_q;
			cnt_rd_q <= (state_q == pba_pkg::ST_OUTRD) ? cnt_mem[idx_q[BW-1:0]] : cnt_rd_q;
		end
		if (state_q == pba_pkg::ST_DIVWT || state_q == pba_pkg::ST_MUL) begin
			sum_rd_q <= sum_mem[(state_q == pba_pkg::ST_MUL) ? BW'(0) : bin_sel];
			cnt_rd_q <= cnt_mem[(state_q == pba_pkg::ST_MUL) ? BW'(0) : bin_sel];
		end
		if (state_q == pba_pkg::ST_CLEAR) begin
			sum_mem[idx_q[BW-1:0]] <= '0;
			cnt_mem[idx_q[BW-1:0]] <= '0;
		end
		if (state_q == pba_pkg::ST_ACC) begin
			sum_mem[bin_q] <= SW'(sum_rd_q + SW'(val_rd_q));
			cnt_mem[bin_q] <= cnt_rd_q + 1'b1;
		end
		if (state_q == pba_pkg::ST_OUTDIV) neg_q <= sum_rd_q[SW-1];
	end

	logic [DW-1:0] mag;
	assign mag = drsp.quo;
	assign bin_index = idx_q[BW-1:0];
	assign bin_mean = (cnt_rd_q == '0) ? 16'sd0 : (neg_q ? 16'(-mag[15:0]) : 16'(mag[15:0]));
	assign bin_count = (cnt_rd_q > CW'(8191)) ? 13'd8191 : 13'(cnt_rd_q);
	assign dropped_voxels = ovf_q;
	assign last_bin = (idx_q == CW'(beff - 1'b1));

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready during output");
	a_vcnt: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CW'(pba_pkg::MaxVoxels)) else $error("voxel count beyond store");
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_bin) |=> (vcnt_q == '0 && !ovf_q)) else $error("run not cleared");
endmodule
`default_nettype wire
